@@ rtl/ssim_pkg.sv @@
package ssim_pkg;

    // widths of one row's contribution for one four-pixel block
    localparam int RowSumW = 10;
    localparam int RowSqW  = 20;
    localparam int RowXW   = 18;

    // accumulator widths
    localparam int AccSumW = 12;
    localparam int AccSqW  = 22;
    localparam int AccXW   = 21;

    // result field widths
    localparam int OutSumW = 12;
    localparam int OutSqW  = 21;
    localparam int OutXW   = 20;

    localparam int BlockPix = 4;
    localparam int PixW     = 8;

    typedef struct packed {
        logic [RowSumW-1:0] sum_first;
        logic [RowSumW-1:0] sum_second;
        logic [RowSqW-1:0]  sum_squares;
        logic [RowXW-1:0]   sum_cross;
    } t_row_sums;

    // beat passed from the front part to the back part
    typedef struct packed {
        t_row_sums [1:0] blk;
        logic            last;
    } t_mid;

    typedef struct packed {
        logic [OutSumW-1:0] sum_first;
        logic [OutSumW-1:0] sum_second;
        logic [OutSqW-1:0]  sum_squares;
        logic [OutXW-1:0]   sum_cross;
    } t_blk_result;

    typedef struct packed {
        t_blk_result [1:0] blk;
    } t_result;

    // per-row sums of one block of four pixel pairs
    function automatic t_row_sums row_block_sums(
        input logic [BlockPix*PixW-1:0] a4,
        input logic [BlockPix*PixW-1:0] d4
    );
        t_row_sums      s;
        logic [PixW-1:0] a;
        logic [PixW-1:0] d;
        s = '0;
        for (int c = 0; c < BlockPix; c++) begin
            a = a4[c*PixW +: PixW];
            d = d4[c*PixW +: PixW];
            s.sum_first   = s.sum_first + RowSumW'(a);
            s.sum_second  = s.sum_second + RowSumW'(d);
            s.sum_squares = s.sum_squares + RowSqW'(a * a) + RowSqW'(d * d);
            s.sum_cross   = s.sum_cross + RowXW'(a * d);
        end
        return s;
    endfunction

    // saturating accumulate, one function per accumulator width
    function automatic logic [AccSumW-1:0] sat_add_sum(
        input logic [AccSumW-1:0] acc,
        input logic [RowSumW-1:0] add
    );
        logic [AccSumW:0] s;
        s = {1'b0, acc} + (AccSumW+1)'(add);
        return s[AccSumW] ? '1 : s[AccSumW-1:0];
    endfunction

    function automatic logic [AccSqW-1:0] sat_add_sq(
        input logic [AccSqW-1:0] acc,
        input logic [RowSqW-1:0] add
    );
        logic [AccSqW:0] s;
        s = {1'b0, acc} + (AccSqW+1)'(add);
        return s[AccSqW] ? '1 : s[AccSqW-1:0];
    endfunction

    function automatic logic [AccXW-1:0] sat_add_x(
        input logic [AccXW-1:0] acc,
        input logic [RowXW-1:0] add
    );
        logic [AccXW:0] s;
        s = {1'b0, acc} + (AccXW+1)'(add);
        return s[AccXW] ? '1 : s[AccXW-1:0];
    endfunction

endpackage

@@ rtl/ssim_fifo.sv @@
module ssim_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/ssim_front.sv @@
module ssim_front #(
    parameter int BLOCK_ROWS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [63:0]         i_row_first,
    input  logic [63:0]         i_row_second,
    output logic                o_full,
    output logic                o_valid,
    output ssim_pkg::t_mid      o_mid,
    input  logic                i_take
);

    localparam int CNTW = $clog2(BLOCK_ROWS);

    logic            r_valid;
    ssim_pkg::t_mid  r_mid;
    ssim_pkg::t_mid  n_mid;
    logic [CNTW-1:0] r_cnt;
    logic            accept;
    logic            is_last;

    assign o_full  = r_valid && !i_take;
    assign accept  = i_push && !o_full;
    assign is_last = (r_cnt == CNTW'(BLOCK_ROWS - 1));
    assign o_valid = r_valid;
    assign o_mid   = r_mid;

    // classify the row and reduce each block to its row sums
    always_comb begin
        n_mid.blk[0] = ssim_pkg::row_block_sums(i_row_first[31:0], i_row_second[31:0]);
        n_mid.blk[1] = ssim_pkg::row_block_sums(i_row_first[63:32], i_row_second[63:32]);
        n_mid.last   = is_last;
    end

    // row counter and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_cnt   <= is_last ? '0 : r_cnt + 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid <= n_mid;
        end
    end

endmodule

@@ rtl/ssim_back.sv @@
module ssim_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  ssim_pkg::t_mid      i_mid,
    output logic                o_pop,
    input  logic                i_full,
    output logic                o_push,
    output ssim_pkg::t_result   o_result
);

    logic [ssim_pkg::AccSumW-1:0] r_acc_first  [2];
    logic [ssim_pkg::AccSumW-1:0] r_acc_second [2];
    logic [ssim_pkg::AccSqW-1:0]  r_acc_sq     [2];
    logic [ssim_pkg::AccXW-1:0]   r_acc_x      [2];
    logic [ssim_pkg::AccSumW-1:0] n_acc_first  [2];
    logic [ssim_pkg::AccSumW-1:0] n_acc_second [2];
    logic [ssim_pkg::AccSqW-1:0]  n_acc_sq     [2];
    logic [ssim_pkg::AccXW-1:0]   n_acc_x      [2];

    // a closing row waits until the result queue has room
    assign o_pop  = !i_empty && (!i_mid.last || !i_full);
    assign o_push = o_pop && i_mid.last;

    // saturating accumulate and result narrowing
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            n_acc_first[b]  = ssim_pkg::sat_add_sum(r_acc_first[b], i_mid.blk[b].sum_first);
            n_acc_second[b] = ssim_pkg::sat_add_sum(r_acc_second[b], i_mid.blk[b].sum_second);
            n_acc_sq[b]     = ssim_pkg::sat_add_sq(r_acc_sq[b], i_mid.blk[b].sum_squares);
            n_acc_x[b]      = ssim_pkg::sat_add_x(r_acc_x[b], i_mid.blk[b].sum_cross);

            o_result.blk[b].sum_first  = n_acc_first[b];
            o_result.blk[b].sum_second = n_acc_second[b];
            o_result.blk[b].sum_squares =
                n_acc_sq[b][ssim_pkg::AccSqW-1] ? '1 : n_acc_sq[b][ssim_pkg::OutSqW-1:0];
            o_result.blk[b].sum_cross =
                n_acc_x[b][ssim_pkg::AccXW-1] ? '1 : n_acc_x[b][ssim_pkg::OutXW-1:0];
        end
    end

    // accumulators, cleared after each closing row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < 2; b++) begin
                r_acc_first[b]  <= '0;
                r_acc_second[b] <= '0;
                r_acc_sq[b]     <= '0;
                r_acc_x[b]      <= '0;
            end
        end else if (o_pop) begin
            for (int b = 0; b < 2; b++) begin
                r_acc_first[b]  <= i_mid.last ? '0 : n_acc_first[b];
                r_acc_second[b] <= i_mid.last ? '0 : n_acc_second[b];
                r_acc_sq[b]     <= i_mid.last ? '0 : n_acc_sq[b];
                r_acc_x[b]      <= i_mid.last ? '0 : n_acc_x[b];
            end
        end
    end

endmodule

@@ rtl/ssim_block_sums_4x4x2.sv @@
// Block sums for structural-similarity scoring. Each beat on the input queue carries one
// row of eight 8-bit pixels from each of two images; columns 0-3 form the left block and
// columns 4-7 the right block. After every BLOCK_ROWS rows one result beat appears with
// the pixel sums, the sum of squares of both images and the sum of cross products for each
// block. A row pair is accepted every cycle while full is low: the front stage reduces a row to
// its sums and registers them, and the back part folds them into the accumulators, with a two-entry
// queue between them and a two-entry result queue at the output. Accumulators saturate instead
// of wrapping.
module ssim_block_sums_4x4x2 #(
    parameter int BLOCK_ROWS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_row_first,
    input  logic [63:0] i_row_second,
    output logic        empty,
    input  logic        pop,
    output logic [11:0] o_left_sum_first,
    output logic [11:0] o_left_sum_second,
    output logic [20:0] o_left_sum_squares,
    output logic [19:0] o_left_sum_cross,
    output logic [11:0] o_right_sum_first,
    output logic [11:0] o_right_sum_second,
    output logic [20:0] o_right_sum_squares,
    output logic [19:0] o_right_sum_cross
);

    localparam int MidW = $bits(ssim_pkg::t_mid);
    localparam int ResW = $bits(ssim_pkg::t_result);

    logic              fr_valid;
    ssim_pkg::t_mid    fr_mid;
    logic              mid_full;
    logic              mid_empty;
    ssim_pkg::t_mid    mid_head;
    logic              bk_pop;
    logic              bk_push;
    ssim_pkg::t_result bk_result;
    logic              res_full;
    ssim_pkg::t_result res_head;

    // front: accept and reduce rows
    ssim_front #(
        .BLOCK_ROWS (BLOCK_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_row_first  (i_row_first),
        .i_row_second (i_row_second),
        .o_full       (full),
        .o_valid      (fr_valid),
        .o_mid        (fr_mid),
        .i_take       (fr_valid && !mid_full)
    );

    // queue between front and back
    ssim_fifo #(
        .WIDTH (MidW),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (fr_mid),
        .o_full  (mid_full),
        .i_pop   (bk_pop),
        .o_data  (mid_head),
        .o_empty (mid_empty)
    );

    // back: accumulate and close groups
    ssim_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (mid_empty),
        .i_mid    (mid_head),
        .o_pop    (bk_pop),
        .i_full   (res_full),
        .o_push   (bk_push),
        .o_result (bk_result)
    );

    // result queue
    ssim_fifo #(
        .WIDTH (ResW),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_push),
        .i_data  (bk_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_left_sum_first    = res_head.blk[0].sum_first;
    assign o_left_sum_second   = res_head.blk[0].sum_second;
    assign o_left_sum_squares  = res_head.blk[0].sum_squares;
    assign o_left_sum_cross    = res_head.blk[0].sum_cross;
    assign o_right_sum_first   = res_head.blk[1].sum_first;
    assign o_right_sum_second  = res_head.blk[1].sum_second;
    assign o_right_sum_squares = res_head.blk[1].sum_squares;
    assign o_right_sum_cross   = res_head.blk[1].sum_cross;

endmodule

@@ verif/tb.sv @@
module tb;

    localparam int GROUP_ROWS  = 4;
    localparam int N_RANDOM    = 552;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 20;

    // one pending row pair with its lead-in gap and a drain request
    typedef struct packed {
        logic [63:0] first;
        logic [63:0] second;
        logic [3:0]  gap;
        logic        drain;
    } t_row_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [63:0] i_row_first = '0;
    logic [63:0] i_row_second = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [11:0] o_left_sum_first;
    logic [11:0] o_left_sum_second;
    logic [20:0] o_left_sum_squares;
    logic [19:0] o_left_sum_cross;
    logic [11:0] o_right_sum_first;
    logic [11:0] o_right_sum_second;
    logic [20:0] o_right_sum_squares;
    logic [19:0] o_right_sum_cross;

    t_row_pair         pending[$];
    ssim_pkg::t_result sums_due[$];
    int          n_total = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          mismatches = 0;
    int          tx_wait = -1;
    int          rx_wait = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // running sums of the current group of rows
    int unsigned rows_seen;
    int unsigned acc_first[2];
    int unsigned acc_second[2];
    int unsigned acc_squares[2];
    int unsigned acc_cross[2];

    ssim_block_sums_4x4x2 #(
        .BLOCK_ROWS(GROUP_ROWS)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_row_first         (i_row_first),
        .i_row_second        (i_row_second),
        .empty               (empty),
        .pop                 (pop),
        .o_left_sum_first    (o_left_sum_first),
        .o_left_sum_second   (o_left_sum_second),
        .o_left_sum_squares  (o_left_sum_squares),
        .o_left_sum_cross    (o_left_sum_cross),
        .o_right_sum_first   (o_right_sum_first),
        .o_right_sum_second  (o_right_sum_second),
        .o_right_sum_squares (o_right_sum_squares),
        .o_right_sum_cross   (o_right_sum_cross)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int unsigned clamp(input int unsigned v, input int w);
        int unsigned lim;
        lim = (32'd1 << w) - 32'd1;
        return (v > lim) ? lim : v;
    endfunction

    // fold one accepted row pair into the group sums, queue a result at group end
    task automatic fold_row(input logic [63:0] ra, input logic [63:0] rb);
        int unsigned       a;
        int unsigned       d;
        int unsigned       s_a;
        int unsigned       s_b;
        int unsigned       s_q;
        int unsigned       s_x;
        ssim_pkg::t_result r;
        for (int b = 0; b < 2; b++) begin
            s_a = 0;
            s_b = 0;
            s_q = 0;
            s_x = 0;
            for (int c = 0; c < ssim_pkg::BlockPix; c++) begin
                a = 32'(ra[(b*ssim_pkg::BlockPix + c)*ssim_pkg::PixW +: ssim_pkg::PixW]);
                d = 32'(rb[(b*ssim_pkg::BlockPix + c)*ssim_pkg::PixW +: ssim_pkg::PixW]);
                s_a += a;
                s_b += d;
                s_q += a * a + d * d;
                s_x += a * d;
            end
            acc_first[b]   = clamp(acc_first[b] + s_a, ssim_pkg::AccSumW);
            acc_second[b]  = clamp(acc_second[b] + s_b, ssim_pkg::AccSumW);
            acc_squares[b] = clamp(acc_squares[b] + s_q, ssim_pkg::AccSqW);
            acc_cross[b]   = clamp(acc_cross[b] + s_x, ssim_pkg::AccXW);
        end
        rows_seen++;
        if (rows_seen == GROUP_ROWS) begin
            for (int b = 0; b < 2; b++) begin
                r.blk[b].sum_first   =
                    (ssim_pkg::OutSumW)'(clamp(acc_first[b], ssim_pkg::OutSumW));
                r.blk[b].sum_second  =
                    (ssim_pkg::OutSumW)'(clamp(acc_second[b], ssim_pkg::OutSumW));
                r.blk[b].sum_squares =
                    (ssim_pkg::OutSqW)'(clamp(acc_squares[b], ssim_pkg::OutSqW));
                r.blk[b].sum_cross   =
                    (ssim_pkg::OutXW)'(clamp(acc_cross[b], ssim_pkg::OutXW));
                acc_first[b]   = 0;
                acc_second[b]  = 0;
                acc_squares[b] = 0;
                acc_cross[b]   = 0;
            end
            rows_seen = 0;
            sums_due.push_back(r);
        end
    endtask

    task automatic add_row(input logic [63:0] ra, input logic [63:0] rb,
                           input int gap, input bit drain);
        t_row_pair p;
        p.first  = ra;
        p.second = rb;
        p.gap    = 4'(gap);
        p.drain  = drain;
        pending.push_back(p);
        n_total++;
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected %0d, got %0d", n_results, what, want, got);
        end
    endtask

    // driver: offers the head of the pending list after its gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                fold_row(i_row_first, i_row_second);
                n_accepted++;
            end
            if (!push || !full) begin
                if (pending.size() != 0 && tx_wait < 0)
                    tx_wait = int'(pending[0].gap);
                if (pending.size() == 0) begin
                    push <= 1'b0;
                end else if (tx_wait > 0) begin
                    tx_wait--;
                    push <= 1'b0;
                end else if (pending[0].drain && sums_due.size() != 0) begin
                    // sender waits here until every result is out
                    push <= 1'b0;
                end else begin
                    i_row_first  <= pending[0].first;
                    i_row_second <= pending[0].second;
                    push <= 1'b1;
                    void'(pending.pop_front());
                    tx_wait = -1;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps going
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: takes result beats and checks them against the oldest expectation
    always @(posedge i_clk) begin
        ssim_pkg::t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (sums_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", n_results);
                end else begin
                    want = sums_due.pop_front();
                    check_field("left first", want.blk[0].sum_first, o_left_sum_first);
                    check_field("left second", want.blk[0].sum_second, o_left_sum_second);
                    check_field("left squares", want.blk[0].sum_squares, o_left_sum_squares);
                    check_field("left cross", want.blk[0].sum_cross, o_left_sum_cross);
                    check_field("right first", want.blk[1].sum_first, o_right_sum_first);
                    check_field("right second", want.blk[1].sum_second, o_right_sum_second);
                    check_field("right squares", want.blk[1].sum_squares,
                                o_right_sum_squares);
                    check_field("right cross", want.blk[1].sum_cross, o_right_sum_cross);
                end
                n_results++;
                // every third stretch of results is taken without idling
                rx_wait = (((n_results / 16) % 3) == 0) ? 0 : $urandom_range(0, 8);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            pop <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // stimulus and end of run
    initial begin
        logic [63:0] ra;
        logic [63:0] rb;
        int          mode;
        int          gap;
        int          idx;
        rows_seen = 0;
        for (int b = 0; b < 2; b++) begin
            acc_first[b]   = 0;
            acc_second[b]  = 0;
            acc_squares[b] = 0;
            acc_cross[b]   = 0;
        end

        // all zero and all full-range pixels
        repeat (4) add_row(64'h0, 64'h0, 0, 1'b0);
        repeat (4) add_row({8{8'hFF}}, {8{8'hFF}}, 0, 1'b0);
        // one image dark, the other bright
        add_row({8{8'hFF}}, 64'h0, 0, 1'b0);
        add_row(64'h0, {8{8'hFF}}, 1, 1'b0);
        add_row({8{8'hFF}}, 64'h0, 0, 1'b0);
        add_row(64'h0, {8{8'hFF}}, 2, 1'b0);
        // alternating bit patterns
        add_row({8{8'hAA}}, {8{8'h55}}, 0, 1'b0);
        add_row({8{8'hAA}}, {8{8'h55}}, 0, 1'b0);
        add_row({8{8'h55}}, {8{8'hAA}}, 0, 1'b0);
        add_row({8{8'h55}}, {8{8'hAA}}, 1, 1'b0);
        // mixed pixel patterns, most with pixels that differ per column
        add_row(64'h0706050403020100, 64'h8081828384858687, 0, 1'b0);
        add_row(64'hF0E0D0C0B0A09080, 64'h0F1F2F3F4F5F6F7F, 0, 1'b0);
        add_row(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 0, 1'b0);
        add_row(64'h8000000000000080, 64'h0100000000000001, 0, 1'b0);
        add_row({8{8'h7F}}, {8{8'h80}}, 0, 1'b0);
        add_row(64'hFF00FF00FF00FF00, 64'h00FF00FF00FF00FF, 0, 1'b0);
        add_row(64'h00000000FFFFFFFF, 64'hFFFFFFFF00000000, 3, 1'b0);
        add_row(64'h01020408102040FF, 64'hFF40201008040201, 0, 1'b0);

        // random rows, drained once after the directed part and once before row 400
        mode = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            idx = n_total;
            if (i % 40 == 0)
                mode = $urandom_range(0, 2);
            if ($urandom_range(0, 9) < 7) begin
                ra = {$urandom, $urandom};
                rb = {$urandom, $urandom};
            end else begin
                // bias pixels towards the range ends
                for (int k = 0; k < 8; k++) begin
                    case ($urandom_range(0, 3))
                        0: ra[k*8 +: 8] = 8'h00;
                        1: ra[k*8 +: 8] = 8'hFF;
                        default: ra[k*8 +: 8] = 8'($urandom_range(0, 255));
                    endcase
                    case ($urandom_range(0, 3))
                        0: rb[k*8 +: 8] = 8'h00;
                        1: rb[k*8 +: 8] = 8'hFF;
                        default: rb[k*8 +: 8] = 8'($urandom_range(0, 255));
                    endcase
                end
            end
            if (mode == 0 || (idx >= 100 && idx < 260))
                gap = 0;
            else
                gap = $urandom_range(0, 8);
            add_row(ra, rb, gap, (i == 0) || (idx == 400));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_total)
            @(posedge i_clk);
        while (sums_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && sums_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ssim_pkg.sv
rtl/ssim_fifo.sv
rtl/ssim_front.sv
rtl/ssim_back.sv
rtl/ssim_block_sums_4x4x2.sv
verif/tb.sv
